// ===== hdl/rvid_pkg.sv =====
package rvid_pkg;

    // major opcodes
    localparam logic [6:0] OPC_SYSTEM = 7'b1110011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_OP_IMM = 7'b0010011;
    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_OP_32  = 7'b0111011;
    localparam logic [6:0] OPC_IMM_32 = 7'b0011011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_TRAP   = 7'b1101011;
    localparam logic [6:0] OPC_LUI    = 7'b0110111;

    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;
    localparam logic [6:0] F7_MUL  = 7'b0000001;
    localparam logic [5:0] F6_BASE = 6'b000000;
    localparam logic [5:0] F6_ALT  = 6'b010000;

    typedef enum logic [2:0] {
        FMT_I    = 3'd0,
        FMT_R    = 3'd1,
        FMT_S    = 3'd2,
        FMT_B    = 3'd3,
        FMT_U    = 3'd4,
        FMT_J    = 3'd5,
        FMT_NONE = 3'd6
    } fmt_t;

    // dense operation numbers
    localparam logic [5:0] OP_INVALID = 6'd0;
    localparam logic [5:0] OP_EBREAK  = 6'd1;
    localparam logic [5:0] OP_LB      = 6'd2;
    localparam logic [5:0] OP_LH      = 6'd3;
    localparam logic [5:0] OP_LW      = 6'd4;
    localparam logic [5:0] OP_LD      = 6'd5;
    localparam logic [5:0] OP_LBU     = 6'd6;
    localparam logic [5:0] OP_LHU     = 6'd7;
    localparam logic [5:0] OP_LWU     = 6'd8;
    localparam logic [5:0] OP_SB      = 6'd9;
    localparam logic [5:0] OP_SH      = 6'd10;
    localparam logic [5:0] OP_SW      = 6'd11;
    localparam logic [5:0] OP_SD      = 6'd12;
    localparam logic [5:0] OP_ADDI    = 6'd13;
    localparam logic [5:0] OP_SLLI    = 6'd14;
    localparam logic [5:0] OP_SLTI    = 6'd15;
    localparam logic [5:0] OP_SLTIU   = 6'd16;
    localparam logic [5:0] OP_XORI    = 6'd17;
    localparam logic [5:0] OP_ORI     = 6'd18;
    localparam logic [5:0] OP_ANDI    = 6'd19;
    localparam logic [5:0] OP_SRLI    = 6'd20;
    localparam logic [5:0] OP_SRAI    = 6'd21;
    localparam logic [5:0] OP_ADD     = 6'd22;
    localparam logic [5:0] OP_SUB     = 6'd23;
    localparam logic [5:0] OP_SLL     = 6'd24;
    localparam logic [5:0] OP_SLT     = 6'd25;
    localparam logic [5:0] OP_SLTU    = 6'd26;
    localparam logic [5:0] OP_XOR     = 6'd27;
    localparam logic [5:0] OP_OR      = 6'd28;
    localparam logic [5:0] OP_AND     = 6'd29;
    localparam logic [5:0] OP_SRL     = 6'd30;
    localparam logic [5:0] OP_SRA     = 6'd31;
    localparam logic [5:0] OP_ADDW    = 6'd32;
    localparam logic [5:0] OP_SUBW    = 6'd33;
    localparam logic [5:0] OP_MULW    = 6'd34;
    localparam logic [5:0] OP_SLLW    = 6'd35;
    localparam logic [5:0] OP_SRLW    = 6'd36;
    localparam logic [5:0] OP_SRAW    = 6'd37;
    localparam logic [5:0] OP_DIVW    = 6'd38;
    localparam logic [5:0] OP_ADDIW   = 6'd39;
    localparam logic [5:0] OP_SLLIW   = 6'd40;
    localparam logic [5:0] OP_SRLIW   = 6'd41;
    localparam logic [5:0] OP_SRAIW   = 6'd42;
    localparam logic [5:0] OP_BEQ     = 6'd43;
    localparam logic [5:0] OP_BNE     = 6'd44;
    localparam logic [5:0] OP_BLT     = 6'd45;
    localparam logic [5:0] OP_BGE     = 6'd46;
    localparam logic [5:0] OP_BLTU    = 6'd47;
    localparam logic [5:0] OP_BGEU    = 6'd48;
    localparam logic [5:0] OP_AUIPC   = 6'd49;
    localparam logic [5:0] OP_JAL     = 6'd50;
    localparam logic [5:0] OP_JALR    = 6'd51;
    localparam logic [5:0] OP_TRAP    = 6'd52;
    localparam logic [5:0] OP_LUI     = 6'd53;

    typedef struct packed {
        logic [5:0]         op_id;
        fmt_t               fmt;
        logic [4:0]         src1_reg;
        logic [4:0]         src2_reg;
        logic [4:0]         dest_reg;
        logic               dest_writes;
        logic signed [31:0] immediate;
    } dec_t;

    function automatic dec_t decode(input logic [31:0] x);
        dec_t       r;
        logic [6:0] opc;
        logic [2:0] f3;
        logic [6:0] f7;
        logic [5:0] f6;
        logic [5:0] id;
        fmt_t       fmt;
        opc = x[6:0];
        f3  = x[14:12];
        f7  = x[31:25];
        f6  = x[31:26];
        id  = OP_INVALID;
        fmt = FMT_NONE;

        unique case (opc)
            OPC_SYSTEM:
            begin
                fmt = FMT_I;
                id  = (f3 == 3'd0) ? OP_EBREAK : OP_INVALID;
            end
            OPC_LOAD:
            begin
                fmt = FMT_I;
                unique case (f3)
                    3'd0:    id = OP_LB;
                    3'd1:    id = OP_LH;
                    3'd2:    id = OP_LW;
                    3'd3:    id = OP_LD;
                    3'd4:    id = OP_LBU;
                    3'd5:    id = OP_LHU;
                    3'd6:    id = OP_LWU;
                    default: id = OP_INVALID;
                endcase
            end
            OPC_STORE:
            begin
                fmt = FMT_S;
                unique case (f3)
                    3'd0:    id = OP_SB;
                    3'd1:    id = OP_SH;
                    3'd2:    id = OP_SW;
                    3'd3:    id = OP_SD;
                    default: id = OP_INVALID;
                endcase
            end
            OPC_OP_IMM:
            begin
                fmt = FMT_I;
                unique case (f3)
                    3'd0:    id = OP_ADDI;
                    3'd1:    id = (f6 == F6_BASE) ? OP_SLLI : OP_INVALID;
                    3'd2:    id = OP_SLTI;
                    3'd3:    id = OP_SLTIU;
                    3'd4:    id = OP_XORI;
                    3'd5:    id = (f6 == F6_BASE) ? OP_SRLI :
                                  (f6 == F6_ALT)  ? OP_SRAI : OP_INVALID;
                    3'd6:    id = OP_ORI;
                    default: id = OP_ANDI;
                endcase
            end
            OPC_OP:
            begin
                fmt = FMT_R;
                if (f7 == F7_BASE)
                begin
                    unique case (f3)
                        3'd0:    id = OP_ADD;
                        3'd1:    id = OP_SLL;
                        3'd2:    id = OP_SLT;
                        3'd3:    id = OP_SLTU;
                        3'd4:    id = OP_XOR;
                        3'd5:    id = OP_SRL;
                        3'd6:    id = OP_OR;
                        default: id = OP_AND;
                    endcase
                end
                else if (f7 == F7_ALT)
                begin
                    id = (f3 == 3'd0) ? OP_SUB : (f3 == 3'd5) ? OP_SRA : OP_INVALID;
                end
            end
            OPC_OP_32:
            begin
                fmt = FMT_R;
                if (f7 == F7_BASE)
                begin
                    id = (f3 == 3'd0) ? OP_ADDW :
                         (f3 == 3'd1) ? OP_SLLW :
                         (f3 == 3'd5) ? OP_SRLW : OP_INVALID;
                end
                else if (f7 == F7_ALT)
                begin
                    id = (f3 == 3'd0) ? OP_SUBW : (f3 == 3'd5) ? OP_SRAW : OP_INVALID;
                end
                else if (f7 == F7_MUL)
                begin
                    id = (f3 == 3'd0) ? OP_MULW : (f3 == 3'd4) ? OP_DIVW : OP_INVALID;
                end
            end
            OPC_IMM_32:
            begin
                fmt = FMT_I;
                if (f3 == 3'd0)
                    id = OP_ADDIW;
                else if (f3 == 3'd1)
                    id = (f7 == F7_BASE) ? OP_SLLIW : OP_INVALID;
                else if (f3 == 3'd5)
                    id = (f7 == F7_BASE) ? OP_SRLIW :
                         (f7 == F7_ALT)  ? OP_SRAIW : OP_INVALID;
            end
            OPC_BRANCH:
            begin
                fmt = FMT_B;
                unique case (f3)
                    3'd0:    id = OP_BEQ;
                    3'd1:    id = OP_BNE;
                    3'd4:    id = OP_BLT;
                    3'd5:    id = OP_BGE;
                    3'd6:    id = OP_BLTU;
                    3'd7:    id = OP_BGEU;
                    default: id = OP_INVALID;
                endcase
            end
            OPC_AUIPC:
            begin
                fmt = FMT_U;
                id  = OP_AUIPC;
            end
            OPC_JAL:
            begin
                fmt = FMT_J;
                id  = OP_JAL;
            end
            OPC_JALR:
            begin
                fmt = FMT_I;
                id  = (f3 == 3'd0) ? OP_JALR : OP_INVALID;
            end
            OPC_TRAP:
            begin
                fmt = FMT_NONE;
                id  = OP_TRAP;
            end
            OPC_LUI:
            begin
                fmt = FMT_U;
                id  = OP_LUI;
            end
            default:
            begin
                fmt = FMT_NONE;
                id  = OP_INVALID;
            end
        endcase

        if (id == OP_INVALID)
            fmt = FMT_NONE;

        r.op_id       = id;
        r.fmt         = fmt;
        r.src1_reg    = '0;
        r.src2_reg    = '0;
        r.dest_reg    = '0;
        r.immediate   = '0;

        unique case (fmt)
            FMT_I:
            begin
                r.src1_reg  = x[19:15];
                r.dest_reg  = x[11:7];
                r.immediate = {{20{x[31]}}, x[31:20]};
            end
            FMT_R:
            begin
                r.src1_reg = x[19:15];
                r.src2_reg = x[24:20];
                r.dest_reg = x[11:7];
            end
            FMT_S:
            begin
                r.src1_reg  = x[19:15];
                r.src2_reg  = x[24:20];
                r.immediate = {{20{x[31]}}, x[31:25], x[11:7]};
            end
            FMT_B:
            begin
                r.src1_reg  = x[19:15];
                r.src2_reg  = x[24:20];
                r.immediate = {{19{x[31]}}, x[31], x[7], x[30:25], x[11:8], 1'b0};
            end
            FMT_U:
            begin
                r.dest_reg  = x[11:7];
                r.immediate = {x[31:12], 12'b0};
            end
            FMT_J:
            begin
                r.dest_reg  = x[11:7];
                r.immediate = {{11{x[31]}}, x[31], x[19:12], x[20], x[30:21], 1'b0};
            end
            default:
            begin
                r.src1_reg = '0;
            end
        endcase

        // dest_reg is already zero for formats without rd
        r.dest_writes = (r.dest_reg != 5'd0);
        return r;
    endfunction

endpackage

// ===== hdl/rv64i_instruction_decoder_unit.sv =====
// Decodes one RV64I instruction word per clock while req_stall is low into an operation number,
// format, register fields, a write flag and the sign-extended immediate. The request is captured
// in an input register, decoded by one level of logic and held in a result register, from which
// the result leaves; a new request can be taken every cycle unless req_stall is raised.
// rsp_stall holds the result register; the input register keeps accepting while it is empty
// or moving forward, so req_stall rises only when both stages are full and the result is held.
module rv64i_instruction_decoder_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [31:0]        instruction,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [5:0]         op_id,
    output logic [2:0]         format,
    output logic [4:0]         src1_reg,
    output logic [4:0]         src2_reg,
    output logic [4:0]         dest_reg,
    output logic               dest_writes,
    output logic signed [31:0] immediate
);

    logic               in_valid_reg;
    logic [31:0]        instr_reg;
    logic               out_valid_reg;
    rvid_pkg::dec_t     out_reg;
    rvid_pkg::dec_t     dec_next;
    logic               out_load;
    logic               in_load;

    // result register frees up when empty or being taken this cycle
    assign out_load  = !out_valid_reg || !rsp_stall;
    assign in_load   = !in_valid_reg || out_load;
    assign req_stall = !in_load;

    assign dec_next = rvid_pkg::decode(instr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_load)
                in_valid_reg <= req_valid;
            if (out_load)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load && req_valid)
            instr_reg <= instruction;
        if (out_load && in_valid_reg)
            out_reg <= dec_next;
    end

    assign rsp_valid   = out_valid_reg;
    assign op_id       = out_reg.op_id;
    assign format      = 3'(out_reg.fmt);
    assign src1_reg    = out_reg.src1_reg;
    assign src2_reg    = out_reg.src2_reg;
    assign dest_reg    = out_reg.dest_reg;
    assign dest_writes = out_reg.dest_writes;
    assign immediate   = out_reg.immediate;

`ifndef SYNTH
    // an accepted request always lands in the input stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> in_valid_reg)
        else $error("accepted request not captured");

    // a full input stage blocked by a held result is not dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_load) |=> (in_valid_reg && $stable(instr_reg)))
        else $error("input stage lost while stalled");

    // a full input stage reaches the result register when it moves
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_load) |=> rsp_valid)
        else $error("decoded request not presented");

    // invalid and register-register results carry no immediate
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (op_id == rvid_pkg::OP_INVALID || format == 3'(rvid_pkg::FMT_R)))
        |-> (immediate == 32'sd0))
        else $error("unexpected immediate");

    // write flag only with a real destination
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && dest_writes) |-> (dest_reg != 5'd0 && op_id != rvid_pkg::OP_INVALID))
        else $error("write flag without destination");
`endif

endmodule

// ===== verif/rv64i_instruction_decoder_unit_test.sv =====
module rv64i_instruction_decoder_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [6:0] MAJOR_OPC [13] = '{
        rvid_pkg::OPC_SYSTEM, rvid_pkg::OPC_LOAD, rvid_pkg::OPC_OP_IMM, rvid_pkg::OPC_OP,
        rvid_pkg::OPC_OP_32, rvid_pkg::OPC_IMM_32, rvid_pkg::OPC_STORE,
        rvid_pkg::OPC_BRANCH, rvid_pkg::OPC_AUIPC, rvid_pkg::OPC_JAL, rvid_pkg::OPC_JALR,
        rvid_pkg::OPC_TRAP, rvid_pkg::OPC_LUI
    };

    typedef struct {
        logic [5:0]         op;
        rvid_pkg::fmt_t     fmt;
        logic [4:0]         rs1;
        logic [4:0]         rs2;
        logic [4:0]         rd;
        logic               wr;
        logic signed [31:0] imm;
    } decoded_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    logic [31:0]        instruction = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    logic [5:0]         op_id;
    logic [2:0]         format;
    logic [4:0]         src1_reg;
    logic [4:0]         src2_reg;
    logic [4:0]         dest_reg;
    logic               dest_writes;
    logic signed [31:0] immediate;

    decoded_t pending_decodes[$];
    decoded_t oldest;
    int       send_gap_pct = 11;
    int       recv_stall_pct = 80;
    int       mismatch_count = 0;
    int       sent_count = 0;
    int       checked_count = 0;
    int       cycle_count = 0;

    rv64i_instruction_decoder_unit dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .instruction (instruction),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .op_id       (op_id),
        .format      (format),
        .src1_reg    (src1_reg),
        .src2_reg    (src2_reg),
        .dest_reg    (dest_reg),
        .dest_writes (dest_writes),
        .immediate   (immediate)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic decoded_t decode_word(input logic [31:0] w);
        decoded_t   d;
        logic [6:0] opc;
        logic [2:0] f3;
        logic [6:0] f7;
        logic [5:0] f6;
        opc = w[6:0];
        f3  = w[14:12];
        f7  = w[31:25];
        f6  = w[31:26];
        d.op  = rvid_pkg::OP_INVALID;
        d.fmt = rvid_pkg::FMT_NONE;
        d.rs1 = '0;
        d.rs2 = '0;
        d.rd  = '0;
        d.wr  = 1'b0;
        d.imm = '0;

        case (opc)
            rvid_pkg::OPC_SYSTEM:
            begin
                d.fmt = rvid_pkg::FMT_I;
                if (f3 == 3'd0)
                    d.op = rvid_pkg::OP_EBREAK;
            end
            rvid_pkg::OPC_LOAD:
            begin
                d.fmt = rvid_pkg::FMT_I;
                if (f3 != 3'd7)
                    d.op = rvid_pkg::OP_LB + 6'(f3);
            end
            rvid_pkg::OPC_STORE:
            begin
                d.fmt = rvid_pkg::FMT_S;
                if (f3 < 3'd4)
                    d.op = rvid_pkg::OP_SB + 6'(f3);
            end
            rvid_pkg::OPC_OP_IMM:
            begin
                d.fmt = rvid_pkg::FMT_I;
                case (f3)
                    3'd0: d.op = rvid_pkg::OP_ADDI;
                    3'd1: if (f6 == rvid_pkg::F6_BASE) d.op = rvid_pkg::OP_SLLI;
                    3'd2: d.op = rvid_pkg::OP_SLTI;
                    3'd3: d.op = rvid_pkg::OP_SLTIU;
                    3'd4: d.op = rvid_pkg::OP_XORI;
                    3'd5:
                    begin
                        if (f6 == rvid_pkg::F6_BASE)
                            d.op = rvid_pkg::OP_SRLI;
                        else if (f6 == rvid_pkg::F6_ALT)
                            d.op = rvid_pkg::OP_SRAI;
                    end
                    3'd6: d.op = rvid_pkg::OP_ORI;
                    3'd7: d.op = rvid_pkg::OP_ANDI;
                endcase
            end
            rvid_pkg::OPC_OP:
            begin
                d.fmt = rvid_pkg::FMT_R;
                if (f7 == rvid_pkg::F7_BASE)
                begin
                    case (f3)
                        3'd0: d.op = rvid_pkg::OP_ADD;
                        3'd1: d.op = rvid_pkg::OP_SLL;
                        3'd2: d.op = rvid_pkg::OP_SLT;
                        3'd3: d.op = rvid_pkg::OP_SLTU;
                        3'd4: d.op = rvid_pkg::OP_XOR;
                        3'd5: d.op = rvid_pkg::OP_SRL;
                        3'd6: d.op = rvid_pkg::OP_OR;
                        3'd7: d.op = rvid_pkg::OP_AND;
                    endcase
                end
                else if (f7 == rvid_pkg::F7_ALT && f3 == 3'd0)
                    d.op = rvid_pkg::OP_SUB;
                else if (f7 == rvid_pkg::F7_ALT && f3 == 3'd5)
                    d.op = rvid_pkg::OP_SRA;
            end
            rvid_pkg::OPC_OP_32:
            begin
                d.fmt = rvid_pkg::FMT_R;
                if (f7 == rvid_pkg::F7_BASE && f3 == 3'd0)
                    d.op = rvid_pkg::OP_ADDW;
                else if (f7 == rvid_pkg::F7_BASE && f3 == 3'd1)
                    d.op = rvid_pkg::OP_SLLW;
                else if (f7 == rvid_pkg::F7_BASE && f3 == 3'd5)
                    d.op = rvid_pkg::OP_SRLW;
                else if (f7 == rvid_pkg::F7_ALT && f3 == 3'd0)
                    d.op = rvid_pkg::OP_SUBW;
                else if (f7 == rvid_pkg::F7_ALT && f3 == 3'd5)
                    d.op = rvid_pkg::OP_SRAW;
                else if (f7 == rvid_pkg::F7_MUL && f3 == 3'd0)
                    d.op = rvid_pkg::OP_MULW;
                else if (f7 == rvid_pkg::F7_MUL && f3 == 3'd4)
                    d.op = rvid_pkg::OP_DIVW;
            end
            rvid_pkg::OPC_IMM_32:
            begin
                d.fmt = rvid_pkg::FMT_I;
                if (f3 == 3'd0)
                    d.op = rvid_pkg::OP_ADDIW;
                else if (f3 == 3'd1 && f7 == rvid_pkg::F7_BASE)
                    d.op = rvid_pkg::OP_SLLIW;
                else if (f3 == 3'd5 && f7 == rvid_pkg::F7_BASE)
                    d.op = rvid_pkg::OP_SRLIW;
                else if (f3 == 3'd5 && f7 == rvid_pkg::F7_ALT)
                    d.op = rvid_pkg::OP_SRAIW;
            end
            rvid_pkg::OPC_BRANCH:
            begin
                d.fmt = rvid_pkg::FMT_B;
                case (f3)
                    3'd0: d.op = rvid_pkg::OP_BEQ;
                    3'd1: d.op = rvid_pkg::OP_BNE;
                    3'd4: d.op = rvid_pkg::OP_BLT;
                    3'd5: d.op = rvid_pkg::OP_BGE;
                    3'd6: d.op = rvid_pkg::OP_BLTU;
                    3'd7: d.op = rvid_pkg::OP_BGEU;
                    default: d.op = rvid_pkg::OP_INVALID;
                endcase
            end
            rvid_pkg::OPC_AUIPC:
            begin
                d.fmt = rvid_pkg::FMT_U;
                d.op  = rvid_pkg::OP_AUIPC;
            end
            rvid_pkg::OPC_JAL:
            begin
                d.fmt = rvid_pkg::FMT_J;
                d.op  = rvid_pkg::OP_JAL;
            end
            rvid_pkg::OPC_JALR:
            begin
                d.fmt = rvid_pkg::FMT_I;
                if (f3 == 3'd0)
                    d.op = rvid_pkg::OP_JALR;
            end
            rvid_pkg::OPC_TRAP:
            begin
                d.fmt = rvid_pkg::FMT_NONE;
                d.op  = rvid_pkg::OP_TRAP;
            end
            rvid_pkg::OPC_LUI:
            begin
                d.fmt = rvid_pkg::FMT_U;
                d.op  = rvid_pkg::OP_LUI;
            end
            default:
            begin
                d.op = rvid_pkg::OP_INVALID;
            end
        endcase

        if (d.op == rvid_pkg::OP_INVALID)
            d.fmt = rvid_pkg::FMT_NONE;

        // signed operands below sign-extend to 32 bits on assignment
        case (d.fmt)
            rvid_pkg::FMT_I:
            begin
                d.rs1 = w[19:15];
                d.rd  = w[11:7];
                d.imm = $signed(w[31:20]);
            end
            rvid_pkg::FMT_R:
            begin
                d.rs1 = w[19:15];
                d.rs2 = w[24:20];
                d.rd  = w[11:7];
            end
            rvid_pkg::FMT_S:
            begin
                d.rs1 = w[19:15];
                d.rs2 = w[24:20];
                d.imm = $signed({w[31:25], w[11:7]});
            end
            rvid_pkg::FMT_B:
            begin
                d.rs1 = w[19:15];
                d.rs2 = w[24:20];
                d.imm = $signed({w[31], w[7], w[30:25], w[11:8], 1'b0});
            end
            rvid_pkg::FMT_U:
            begin
                d.rd  = w[11:7];
                d.imm = {w[31:12], 12'h000};
            end
            rvid_pkg::FMT_J:
            begin
                d.rd  = w[11:7];
                d.imm = $signed({w[31], w[19:12], w[20], w[30:21], 1'b0});
            end
            default:
            begin
                d.imm = '0;
            end
        endcase

        d.wr = (d.fmt inside {rvid_pkg::FMT_I, rvid_pkg::FMT_R, rvid_pkg::FMT_U,
                              rvid_pkg::FMT_J}) && (d.rd != 5'd0);
        return d;
    endfunction

    function automatic logic [31:0] shaped_word();
        logic [31:0] w;
        w = $urandom;
        // some raw noise, the rest lands on a real major opcode
        if ($urandom_range(0, 99) < 15)
            return w;
        w[6:0] = MAJOR_OPC[$urandom_range(0, 12)];
        case ($urandom_range(0, 5))
            0: w[31:25] = rvid_pkg::F7_BASE;
            1: w[31:25] = rvid_pkg::F7_ALT;
            2: w[31:25] = rvid_pkg::F7_MUL;
            3: w[31:26] = rvid_pkg::F6_BASE;
            4: w[31:26] = rvid_pkg::F6_ALT;
            default: w = w;
        endcase
        if ($urandom_range(0, 7) == 0)
            w[11:7] = 5'd0;
        return w;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch @%0t: %s", $realtime, msg);
    endtask

    task automatic send_request(input logic [31:0] w);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid   <= 1'b1;
        instruction <= w;
        do
        begin
            @(posedge clk);
        end
        while (req_stall);
        @(negedge clk);
        sent_count++;
    endtask

    always @(negedge clk)
    begin
        rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            checked_count++;
            if (pending_decodes.size() == 0)
                flag_mismatch($sformatf("result with no request pending, op_id %0d", op_id));
            else
            begin
                oldest = pending_decodes.pop_front();
                if (op_id !== oldest.op)
                    flag_mismatch($sformatf("op_id %0d, want %0d", op_id, oldest.op));
                if (format !== oldest.fmt)
                    flag_mismatch($sformatf("format %0d, want %0d (op %0d)",
                                            format, oldest.fmt, oldest.op));
                if (src1_reg !== oldest.rs1)
                    flag_mismatch($sformatf("src1_reg %0d, want %0d (op %0d)",
                                            src1_reg, oldest.rs1, oldest.op));
                if (src2_reg !== oldest.rs2)
                    flag_mismatch($sformatf("src2_reg %0d, want %0d (op %0d)",
                                            src2_reg, oldest.rs2, oldest.op));
                if (dest_reg !== oldest.rd)
                    flag_mismatch($sformatf("dest_reg %0d, want %0d (op %0d)",
                                            dest_reg, oldest.rd, oldest.op));
                if (dest_writes !== oldest.wr)
                    flag_mismatch($sformatf("dest_writes %0b, want %0b (op %0d)",
                                            dest_writes, oldest.wr, oldest.op));
                if (immediate !== oldest.imm)
                    flag_mismatch($sformatf("immediate %0d, want %0d (op %0d)",
                                            immediate, oldest.imm, oldest.op));
            end
        end
        if (rst_n && req_valid && !req_stall)
            pending_decodes.push_back(decode_word(instruction));
    end

    task automatic test_corner_words();
        logic [31:0] words [$];
        words = '{
            32'h0000_0000, 32'hFFFF_FFFF,
            32'hFFFF_FFEB,                   // trap opcode with every other bit set
            32'hFFFF_8FF3, 32'h0000_1073,    // system: funct3 zero vs nonzero
            32'h0000_1067, 32'hFFF0_8FE7,    // jalr bad funct3, jalr imm and rd all ones
            32'h0200_1013, 32'h0400_1013,    // slli shamt bit 5, slli bad funct6
            32'h4200_5013, 32'h6000_5013,    // srai shamt bit 5, bad funct6
            32'h0200_101B, 32'h4000_501B,    // slliw bit 25 set, sraiw
            32'h0000_7003, 32'h0000_4023,    // load and store bad funct3
            32'h0000_2063, 32'hFFFF_8FE3,    // branch bad funct3, beq all ones
            32'hFFFF_8FA3, 32'hFFFF_F037,    // sb all ones, lui rd x0
            32'h8000_006F, 32'hFFFF_FFEF,    // jal extremes
            32'hFFF0_0013, 32'h0200_403B,    // addi x0 -1, divw
            32'h0200_603B, 32'h8000_0033     // bad M funct3, bad funct7
        };
        foreach (words[i])
            send_request(words[i]);
    endtask

    task automatic test_opcode_sweep();
        logic [31:0] w;
        for (int o = 0; o < 13; o++)
            for (int f3 = 0; f3 < 8; f3++)
                for (int k = 0; k < 3; k++)
                begin
                    w = $urandom;
                    w[6:0]   = MAJOR_OPC[o];
                    w[14:12] = 3'(f3);
                    w[31:25] = (k == 0) ? rvid_pkg::F7_BASE :
                               (k == 1) ? rvid_pkg::F7_ALT : rvid_pkg::F7_MUL;
                    send_request(w);
                end
    endtask

    task automatic test_random_mix(input int count, input int gap_pct, input int stall_pct);
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            send_request(shaped_word());
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_corner_words();
        test_opcode_sweep();
        test_random_mix(370, 11, 80);
        test_random_mix(370, 80, 11);
        test_random_mix(370, 0, 0);

        req_valid <= 1'b0;
        while (pending_decodes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d instruction words (corner words, opcode sweep, shaped random),",
                 sent_count);
        $display("checked %0d decoded results, %0d mismatches", checked_count, mismatch_count);
        if (mismatch_count == 0 && pending_decodes.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/rvid_pkg.sv
hdl/rv64i_instruction_decoder_unit.sv
verif/rv64i_instruction_decoder_unit_test.sv
